// ===== rtl/rnsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rnsb_pkg
// Shared types and constants of the wall bitmap with rank select and clear.
// ----------------------------------------------------------------------------
package rnsb_pkg;

   localparam int unsigned MAX_WALLS   = 8192;
   localparam int unsigned NUM_BYTES   = MAX_WALLS / 8;
   localparam int unsigned GROUP_BYTES = 16;
   localparam int unsigned NUM_GROUPS  = NUM_BYTES / GROUP_BYTES;
   localparam int unsigned BYTE_AW     = $clog2(NUM_BYTES);
   localparam int unsigned GROUP_AW    = $clog2(NUM_GROUPS);
   localparam int unsigned GB_AW       = $clog2(GROUP_BYTES);
   localparam int unsigned TOTAL_W     = 14;
   localparam int unsigned GCNT_W      = 8;
   localparam int unsigned POS_W       = 13;
   localparam int unsigned NUMBER_W    = 32;
   localparam int unsigned CFG_W       = 7;
   localparam int unsigned DIV_STEPS   = NUMBER_W;
   localparam int unsigned DIVCNT_W    = $clog2(DIV_STEPS);
   localparam int unsigned LEFT_W      = 16;
   localparam logic [CFG_W-1:0] GRID_RESET = 7'd32;

   typedef enum logic [1:0] {
      CMD_FILL       = 2'd0,
      CMD_REMOVE_NTH = 2'd1,
      CMD_REMOVE_AT  = 2'd2,
      CMD_IGNORE     = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FILL,
      ST_IDLE,
      ST_DIV,
      ST_GWALK,
      ST_BWALK,
      ST_ACHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_fill;
      logic fill_step;
      logic div_step;
      logic gwalk;
      logic bwalk;
      logic achk;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic total_zero;
      logic addr_oob;
      logic div_last;
      logic g_stop;
      logic b_stop;
   } dp_status_type;

endpackage

// ===== rtl/rnsb_req_if.sv =====
// ----------------------------------------------------------------------------
// rnsb_req_if
// Request channel: command and number with valid/ready.
// ----------------------------------------------------------------------------
interface rnsb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] number;

   modport source (output valid, output command, output number, input ready);
   modport sink   (input valid, input command, input number, output ready);
endinterface

// ===== rtl/rnsb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rnsb_rsp_if
// Response channel: position, remaining and status with valid/ready.
// ----------------------------------------------------------------------------
interface rnsb_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] position;
   logic [12:0] remaining;
   logic        status;

   modport source (output valid, output position, output remaining, output status,
                   input ready);
   modport sink   (input valid, input position, input remaining, input status,
                   output ready);
endinterface

// ===== rtl/rnsb_ram.sv =====
// ----------------------------------------------------------------------------
// rnsb_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rnsb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rnsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rnsb_ctrl
// Sequencer: fill sweep, rank division, group/byte walks, address check, response hand-off.
// ----------------------------------------------------------------------------
module rnsb_ctrl import rnsb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      respond_ff, respond_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         respond_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         respond_ff   <= respond_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      respond_in = respond_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load_fill = 1'b1;
            state_in      = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               state_in = respond_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (cmd_type'(req_command))
                  CMD_FILL: begin
                     respond_in = 1'b1;
                     state_in   = ST_LOAD;
                  end
                  CMD_REMOVE_NTH: state_in = sts.total_zero ? ST_DONE : ST_DIV;
                  CMD_REMOVE_AT:  state_in = sts.addr_oob ? ST_DONE : ST_ACHK;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_GWALK;
            end
         end
         ST_GWALK: begin
            cmd.gwalk = 1'b1;
            if (sts.g_stop) begin
               state_in = ST_BWALK;
            end
         end
         ST_BWALK: begin
            cmd.bwalk = 1'b1;
            if (sts.b_stop) begin
               state_in = ST_DONE;
            end
         end
         ST_ACHK: begin
            cmd.achk = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // output register free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== rtl/rnsb_datapath.sv =====
// ----------------------------------------------------------------------------
// rnsb_datapath
// Bitmap and group count memories, total, rank divider and walk registers.
// ----------------------------------------------------------------------------
module rnsb_datapath import rnsb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [0:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_data,
   input  logic [NUMBER_W-1:0] req_number,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       sts,
   output logic [POS_W-1:0]    out_position,
   output logic [POS_W-1:0]    out_remaining,
   output logic                out_status
);

   function automatic logic [3:0] popcount8(input logic [7:0] d);
      logic [3:0] c;
      c = '0;
      for (int k = 0; k < 8; k++) begin
         c = c + 4'(d[k]);
      end
      return c;
   endfunction

   // index of the set bit of given rank within a byte
   function automatic logic [2:0] nth_bit(input logic [7:0] d, input logic [2:0] rank);
      logic [3:0] c;
      logic [2:0] sel;
      c   = '0;
      sel = '0;
      for (int k = 0; k < 8; k++) begin
         if (d[k] && c == {1'b0, rank}) begin
            sel = 3'(k);
         end
         c = c + 4'(d[k]);
      end
      return sel;
   endfunction

   logic [CFG_W-1:0]        rows_ff, cols_ff;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [TOTAL_W-1:0]      rem_ff, rem_in;
   logic [NUMBER_W-1:0]     num_ff, num_in;
   logic [DIVCNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [GROUP_AW-1:0]     g_ff, g_in;
   logic [BYTE_AW-1:0]      b_ff, b_in;
   logic [2:0]              bit_ff, bit_in;
   logic [GCNT_W-1:0]       gcnt_ff, gcnt_in;
   logic signed [LEFT_W-1:0] left_ff, left_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    status_ff, status_in;
   logic [POS_W-1:0]        out_pos_ff, out_rem_ff;
   logic                    out_status_ff;

   logic                byte_we, grp_we;
   logic [BYTE_AW-1:0]  byte_waddr;
   logic [7:0]          byte_wdata, byte_rdata;
   logic [GROUP_AW-1:0] grp_waddr;
   logic [GCNT_W-1:0]   grp_wdata, grp_rdata;

   rnsb_ram #(.WIDTH(8), .DEPTH(NUM_BYTES)) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_waddr),
      .wr_data (byte_wdata),
      .rd_addr (b_in),
      .rd_data (byte_rdata)
   );

   rnsb_ram #(.WIDTH(GCNT_W), .DEPTH(NUM_GROUPS)) u_grp_ram (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (grp_waddr),
      .wr_data (grp_wdata),
      .rd_addr (g_in),
      .rd_data (grp_rdata)
   );

   // wall count 2nm - n - m, clamped to [0, MAX_WALLS]
   logic [2*CFG_W-1:0]  prod;
   logic [16:0]         dbl, sub, diff;
   logic [TOTAL_W-1:0]  wc;
   always_comb begin
      prod = (2*CFG_W)'(rows_ff) * (2*CFG_W)'(cols_ff);
      dbl  = {2'b0, prod, 1'b0};
      sub  = 17'(rows_ff) + 17'(cols_ff);
      diff = dbl - sub;
      if (dbl < sub) begin
         wc = '0;
      end else if (diff > 17'(MAX_WALLS)) begin
         wc = TOTAL_W'(MAX_WALLS);
      end else begin
         wc = diff[TOTAL_W-1:0];
      end
   end

   // fill byte from bits left
   logic [3:0]        fill_c;
   logic [7:0]        fill_mask;
   logic [GCNT_W-1:0] acc_sum;
   always_comb begin
      if (left_ff <= 0) begin
         fill_c = '0;
      end else if (left_ff >= 8) begin
         fill_c = 4'd8;
      end else begin
         fill_c = {1'b0, left_ff[2:0]};
      end
      for (int k = 0; k < 8; k++) begin
         fill_mask[k] = (4'(k) < fill_c);
      end
      acc_sum = ((b_ff[GB_AW-1:0] == '0) ? '0 : gcnt_ff) + GCNT_W'(fill_c);
   end

   logic [TOTAL_W:0]   div_t;
   logic               g_ge, b_ge, g_stop, b_stop;
   logic [3:0]         bcnt;
   logic [2:0]         sel_bit;

   assign div_t   = {rem_ff, num_ff[NUMBER_W-1]};
   assign g_ge    = rem_ff >= TOTAL_W'(grp_rdata);
   assign g_stop  = (g_ff == GROUP_AW'(NUM_GROUPS-1)) || !g_ge;
   assign bcnt    = popcount8(byte_rdata);
   assign b_ge    = rem_ff >= TOTAL_W'(bcnt);
   assign b_stop  = (b_ff[GB_AW-1:0] == {GB_AW{1'b1}}) || !b_ge;
   assign sel_bit = nth_bit(byte_rdata, rem_ff[2:0]);

   always_comb begin
      total_in   = total_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      div_cnt_in = div_cnt_ff;
      g_in       = g_ff;
      b_in       = b_ff;
      bit_in     = bit_ff;
      gcnt_in    = gcnt_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      byte_we    = 1'b0;
      byte_waddr = b_ff;
      byte_wdata = fill_mask;
      grp_we     = 1'b0;
      grp_waddr  = g_ff;
      grp_wdata  = acc_sum;
      priority if (cmd.accept) begin
         num_in     = req_number;
         rem_in     = '0;
         div_cnt_in = '0;
         pos_in     = '0;
         status_in  = 1'b1;
         g_in       = req_number[POS_W-1 -: GROUP_AW];
         b_in       = req_number[POS_W-1 -: BYTE_AW];
         bit_in     = req_number[2:0];
      end else if (cmd.load_fill) begin
         left_in   = LEFT_W'(wc);
         total_in  = wc;
         b_in      = '0;
         pos_in    = '0;
         status_in = 1'b0;
      end else if (cmd.fill_step) begin
         byte_we    = 1'b1;
         grp_we     = (b_ff[GB_AW-1:0] == {GB_AW{1'b1}});
         grp_waddr  = b_ff[BYTE_AW-1 -: GROUP_AW];
         b_in       = b_ff + 1'b1;
         gcnt_in    = acc_sum;
         left_in    = left_ff - LEFT_W'(8);
      end else if (cmd.div_step) begin
         if (div_t >= {1'b0, total_ff}) begin
            rem_in = TOTAL_W'(div_t - {1'b0, total_ff});
         end else begin
            rem_in = div_t[TOTAL_W-1:0];
         end
         num_in     = num_ff << 1;
         div_cnt_in = div_cnt_ff + 1'b1;
         g_in       = '0;
      end else if (cmd.gwalk) begin
         if (!g_stop) begin
            rem_in = rem_ff - TOTAL_W'(grp_rdata);
            g_in   = g_ff + 1'b1;
         end else begin
            b_in    = {g_ff, {GB_AW{1'b0}}};
            gcnt_in = grp_rdata;
         end
      end else if (cmd.bwalk) begin
         if (!b_stop) begin
            rem_in = rem_ff - TOTAL_W'(bcnt);
            b_in   = b_ff + 1'b1;
         end else if (!b_ge) begin
            byte_we    = 1'b1;
            byte_wdata = byte_rdata & ~(8'b1 << sel_bit);
            grp_we     = 1'b1;
            grp_wdata  = gcnt_ff - 1'b1;
            total_in   = total_ff - 1'b1;
            pos_in     = {b_ff, sel_bit};
            status_in  = 1'b0;
         end
      end else if (cmd.achk) begin
         if (byte_rdata[bit_ff]) begin
            byte_we    = 1'b1;
            byte_wdata = byte_rdata & ~(8'b1 << bit_ff);
            grp_we     = 1'b1;
            grp_wdata  = grp_rdata - 1'b1;
            total_in   = total_ff - 1'b1;
            pos_in     = {b_ff, bit_ff};
            status_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= GRID_RESET;
         cols_ff <= GRID_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_ROWS: rows_ff <= csr_data;
            CSR_GRID_COLS: cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      div_cnt_ff <= div_cnt_in;
      g_ff       <= g_in;
      b_ff       <= b_in;
      bit_ff     <= bit_in;
      gcnt_ff    <= gcnt_in;
      left_ff    <= left_in;
      pos_ff     <= pos_in;
      status_ff  <= status_in;
      if (cmd.out_load) begin
         out_pos_ff    <= pos_ff;
         out_rem_ff    <= total_ff[POS_W-1:0];
         out_status_ff <= status_ff;
      end
   end

   assign sts.fill_last  = (b_ff == BYTE_AW'(NUM_BYTES-1));
   assign sts.total_zero = (total_ff == '0);
   assign sts.addr_oob   = |req_number[NUMBER_W-1:POS_W];
   assign sts.div_last   = (div_cnt_ff == DIVCNT_W'(DIV_STEPS-1));
   assign sts.g_stop     = g_stop;
   assign sts.b_stop     = b_stop;

   assign out_position  = out_pos_ff;
   assign out_remaining = out_rem_ff;
   assign out_status    = out_status_ff;

endmodule

// ===== rtl/remove_nth_set_bit.sv =====
// ----------------------------------------------------------------------------
// remove_nth_set_bit
// Wall bitmap with group counts: fill, remove the n-th set bit, remove at.
//
//   channel | dir | handshake      | payload
//   req_if  | in  | valid/ready    | command[1:0], number[31:0]
//   rsp_if  | out | valid/ready    | position[12:0], remaining[12:0], status
//   csr     | in  | csr_wr_en      | csr_index[0:0], csr_data[6:0]
//
// Fill: one byte of the bitmap memory written per cycle.
// Remove-nth: 32-step remainder, then one group count and one byte read
// per cycle from the count and bitmap memories.
// Remove-at: one bitmap byte checked. Out of range, an empty map on
// remove-nth or the ignored command go straight to the result.
// One item at a time, ready only in the idle state that follows the loaded
// result or the reset fill; the next item is taken while the result
// register still waits. After reset a fill sweep runs with ready low.
// ----------------------------------------------------------------------------
module remove_nth_set_bit import rnsb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   rnsb_req_if.sink         req_if,
   rnsb_rsp_if.source       rsp_if,
   input  logic             csr_wr_en,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   rnsb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   rnsb_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_number    (req_if.number),
      .cmd           (cmd),
      .sts           (sts),
      .out_position  (rsp_if.position),
      .out_remaining (rsp_if.remaining),
      .out_status    (rsp_if.status)
   );

endmodule
